FILE: rtl/core/tps_pkg.sv
// shared widths, reset values and codes for the trapezoid profile sampler
`timescale 1ns / 1ps
package tps_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int D_W       = 24;
	localparam int T_W       = 32;
	localparam int V_W       = 20;
	localparam int CFG_IDX_W = 1;

	localparam logic [V_W-1:0] SPEED_LIMIT_RST = 20'd45875;
	localparam logic [V_W-1:0] ACCEL_LIMIT_RST = 20'd16384;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_LIMIT = 1'b0,
		REG_ACCEL_LIMIT = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_ACCEL  = 2'd0,
		PH_CRUISE = 2'd1,
		PH_DECEL  = 2'd2
	} phase_t;

endpackage

FILE: rtl/core/tps_if.sv
// valid/ready channel interfaces of the trapezoid profile sampler
`timescale 1ns / 1ps
interface tps_cfg_if import tps_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [V_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

interface tps_sample_if import tps_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [D_W-1:0] path_length;
	logic [T_W-1:0] time_since_start;
	logic [V_W-1:0] entry_speed;
	logic [V_W-1:0] exit_speed;

	modport source (output valid, output path_length, output time_since_start,
		output entry_speed, output exit_speed, input ready);
	modport sink (input valid, input path_length, input time_since_start,
		input entry_speed, input exit_speed, output ready);
endinterface

interface tps_result_if import tps_pkg::*; ();
	logic           valid;
	logic           ready;
	logic [D_W-1:0] ref_position;
	logic [V_W-1:0] ref_speed;
	logic [T_W-1:0] move_duration;

	modport source (output valid, output ref_position, output ref_speed,
		output move_duration, input ready);
	modport sink (input valid, input ref_position, input ref_speed,
		input move_duration, output ready);
endinterface

FILE: rtl/core/tps_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage, with side data
`timescale 1ns / 1ps
module tps_sqrt_pipe #(
	parameter int RW = 45,
	parameter int SW = 1,
	parameter int QW = (RW + 1) / 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [RW-1:0] rad,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] root,
	output logic [SW-1:0] side_out
);

	logic            vld_s  [QW];
	logic [SW-1:0]   side_s [QW];
	logic [2*QW-1:0] rs_s   [QW];
	logic [QW:0]     rem_s  [QW];
	logic [QW-1:0]   root_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stg
		logic            vld_i;
		logic [SW-1:0]   side_i;
		logic [2*QW-1:0] rs_i;
		logic [QW:0]     rem_i;
		logic [QW-1:0]   root_i;
		logic [QW+2:0]   cur;
		logic [QW+2:0]   trial;

		if (k == 0) begin : g_head
			assign vld_i  = in_valid;
			assign side_i = side_in;
			assign rs_i   = (2*QW)'(rad);
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_body
			assign vld_i  = vld_s[k-1];
			assign side_i = side_s[k-1];
			assign rs_i   = rs_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign root_i = root_s[k-1];
		end

		// next two radicand bits against 4*root + 1
		assign cur   = {rem_i, rs_i[2*QW-1 -: 2]};
		assign trial = {1'b0, root_i, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_i;
				rs_s[k]   <= {rs_i[2*QW-3:0], 2'b00};
				if (cur >= trial) begin
					rem_s[k]  <= (QW+1)'(cur - trial);
					root_s[k] <= {root_i[QW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur[QW:0];
					root_s[k] <= {root_i[QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign root      = root_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule

FILE: rtl/core/tps_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, lanes share side data
`timescale 1ns / 1ps
module tps_div_pipe #(
	parameter int NW    = 40,
	parameter int DW    = 21,
	parameter int LANES = 1,
	parameter int SW    = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] num [LANES],
	input  logic [DW-1:0] den [LANES],
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NW-1:0] quo [LANES],
	output logic [SW-1:0] side_out
);

	logic          vld_s  [NW];
	logic [SW-1:0] side_s [NW];
	logic [NW-1:0] nq_s   [NW][LANES];
	logic [DW-1:0] rem_s  [NW][LANES];
	logic [DW-1:0] den_s  [NW][LANES];

	for (genvar k = 0; k < NW; k++) begin : g_stg
		logic          vld_i;
		logic [SW-1:0] side_i;
		logic [NW-1:0] nq_i  [LANES];
		logic [DW-1:0] rem_i [LANES];
		logic [DW-1:0] den_i [LANES];

		if (k == 0) begin : g_head
			assign vld_i  = in_valid;
			assign side_i = side_in;
			for (genvar l = 0; l < LANES; l++) begin : g_ln
				assign nq_i[l]  = num[l];
				assign rem_i[l] = '0;
				assign den_i[l] = den[l];
			end
		end else begin : g_body
			assign vld_i  = vld_s[k-1];
			assign side_i = side_s[k-1];
			for (genvar l = 0; l < LANES; l++) begin : g_ln
				assign nq_i[l]  = nq_s[k-1][l];
				assign rem_i[l] = rem_s[k-1][l];
				assign den_i[l] = den_s[k-1][l];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_i;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DW:0] cur;
			logic [DW:0] dif;

			// numerator bits shift out of the top, quotient bits shift in below
			assign cur = {rem_i[l], nq_i[l][NW-1]};
			assign dif = cur - {1'b0, den_i[l]};

			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k][l] <= den_i[l];
					if (!dif[DW]) begin
						rem_s[k][l] <= dif[DW-1:0];
						nq_s[k][l]  <= {nq_i[l][NW-2:0], 1'b1};
					end else begin
						rem_s[k][l] <= cur[DW-1:0];
						nq_s[k][l]  <= {nq_i[l][NW-2:0], 1'b0};
					end
				end
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign side_out  = side_s[NW-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign quo[l] = nq_s[NW-1][l];
	end

endmodule

FILE: rtl/core/trapezoid_profile_sampler.sv
// trapezoid profile sampler top level: config registers and sample pipeline
//
// Channels: cfg writes speed_limit (index 0) and accel_limit (index 1), both
// raised to at least 0.05 as they are stored; cfg is always ready and should
// only be written while no sample is in flight. samples carries one beat per
// query (path length, elapsed time, entry and exit speed), results carries one
// beat per query (position, speed, total duration) in the same order.
// Throughput: one sample per cycle while results is not stalled. Pipeline
// depth is set by the square root stages, the four-lane time/distance
// divider and the cruise time divider, each one bit per stage.
// Reset clears all pipeline valids and loads the default limits.
// When results stalls the result register holds; bubbles inside the pipe still
// close up, then the whole pipe and samples.ready stall together.
`timescale 1ns / 1ps
module trapezoid_profile_sampler import tps_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	tps_cfg_if.sink     cfg,
	tps_sample_if.sink  samples,
	tps_result_if.source results
);

	localparam int F     = FRAC_BITS;
	localparam int SQ_W  = 2 * V_W;
	localparam int AD_W  = D_W + V_W;
	localparam int RAD_W = AD_W + 1;
	localparam int PK_W  = (RAD_W + 1) / 2;
	localparam int NA_W  = (V_W + F > SQ_W) ? V_W + F : SQ_W;
	localparam int AC2_W = V_W + 1;
	localparam int TC_W  = D_W + F;
	localparam int DUR_W = ((NA_W > TC_W) ? NA_W : TC_W) + 2;
	localparam int M_W   = V_W + T_W;
	localparam int MAG_W = M_W + 1 - F;
	localparam int PW    = ((NA_W + 1 > MAG_W) ? NA_W + 1 : MAG_W) + 1;

	localparam logic [V_W-1:0] K05 = V_W'(((64'd5 << F) + 64'd50) / 64'd100);
	localparam logic [V_W-1:0] THR = V_W'((64'd1 << F) / 64'd10000);
	localparam logic [V_W-1:0] SPD_RST = (SPEED_LIMIT_RST < K05) ? K05 : SPEED_LIMIT_RST;
	localparam logic [V_W-1:0] ACC_RST = (ACCEL_LIMIT_RST < K05) ? K05 : ACCEL_LIMIT_RST;

	typedef struct packed {
		logic [D_W-1:0] d;
		logic [T_W-1:0] el;
		logic [V_W-1:0] v0;
		logic [V_W-1:0] v1;
		logic [V_W-1:0] acc;
		logic [V_W-1:0] vmax;
		logic           tiny;
	} base_t;

	typedef struct packed {
		base_t           b;
		logic [SQ_W-1:0] v0sq;
		logic [SQ_W-1:0] v1sq;
	} sqs_t;

	typedef struct packed {
		base_t          b;
		logic [V_W-1:0] vp;
	} dv1_t;

	typedef struct packed {
		base_t           b;
		logic [V_W-1:0]  vp;
		logic [NA_W-1:0] ta;
		logic [NA_W-1:0] td;
		logic [NA_W-1:0] da;
		logic [D_W-1:0]  dc;
	} dv2_t;

	typedef struct packed {
		base_t            b;
		logic [V_W-1:0]   vp;
		logic [NA_W-1:0]  ta;
		logic [NA_W-1:0]  td;
		logic [NA_W-1:0]  da;
		logic [D_W-1:0]   dc;
		logic [DUR_W-1:0] tatc;
		logic [DUR_W-1:0] dur;
		logic [T_W-1:0]   t;
		logic             fin;
		phase_t           ph;
		logic [T_W-1:0]   x;
		logic [M_W-1:0]   m1;
		logic [M_W-1:0]   m2;
		logic [V_W-1:0]   dv;
		logic [M_W-1:0]   m3;
		logic [V_W:0]     vel;
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic [PW-1:0]    base;
		logic [PW-1:0]    pos;
	} lt_t;

	// configuration
	logic [V_W-1:0] spd_lim_q;
	logic [V_W-1:0] acc_lim_q;
	logic [V_W-1:0] cfg_floor;

	assign cfg.ready = 1'b1;
	assign cfg_floor = (cfg.data < K05) ? K05 : cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_lim_q <= SPD_RST;
			acc_lim_q <= ACC_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_SPEED_LIMIT: spd_lim_q <= cfg_floor;
				REG_ACCEL_LIMIT: acc_lim_q <= cfg_floor;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic en;
	logic out_ld;
	logic res_vld_q;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic v_s9, v_s10, v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18;
	logic v_sq, v_d1, v_d2;

	assign out_ld        = !res_vld_q || results.ready;
	assign en            = out_ld || !v_s18;
	assign samples.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
			{v_s9, v_s10, v_s11, v_s12, v_s13}                <= '0;
			{v_s14, v_s15, v_s16, v_s17, v_s18}               <= '0;
		end else if (en) begin
			v_s1  <= samples.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_sq;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_d1;
			v_s8  <= v_s7;
			v_s9  <= v_d2;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
		end
	end

	// stages 1 to 3: clamp, squares, radicand
	base_t           b_s1, b_s2;
	logic [AD_W-1:0] ad_s2;
	logic [SQ_W-1:0] v0sq_s2, v1sq_s2;
	logic [RAD_W-1:0] rad_s3;
	sqs_t            sq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			b_s1.d    <= samples.path_length;
			b_s1.el   <= samples.time_since_start;
			b_s1.v0   <= (samples.entry_speed > spd_lim_q) ? spd_lim_q : samples.entry_speed;
			b_s1.v1   <= (samples.exit_speed > spd_lim_q) ? spd_lim_q : samples.exit_speed;
			b_s1.acc  <= acc_lim_q;
			b_s1.vmax <= spd_lim_q;
			b_s1.tiny <= samples.path_length <= D_W'(THR);

			b_s2    <= b_s1;
			ad_s2   <= AD_W'(b_s1.acc) * AD_W'(b_s1.d);
			v0sq_s2 <= SQ_W'(b_s1.v0) * SQ_W'(b_s1.v0);
			v1sq_s2 <= SQ_W'(b_s1.v1) * SQ_W'(b_s1.v1);

			rad_s3     <= RAD_W'(ad_s2) + RAD_W'(((SQ_W+1)'(v0sq_s2) + (SQ_W+1)'(v1sq_s2)) >> 1);
			sq_s3.b    <= b_s2;
			sq_s3.v0sq <= v0sq_s2;
			sq_s3.v1sq <= v1sq_s2;
		end
	end

	// unconstrained peak speed
	logic [PK_W-1:0] pk;
	sqs_t            sq_o;

	tps_sqrt_pipe #(
		.RW (RAD_W),
		.SW ($bits(sqs_t)),
		.QW (PK_W)
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.rad       (rad_s3),
		.side_in   (sq_s3),
		.out_valid (v_sq),
		.root      (pk),
		.side_out  (sq_o)
	);

	// stages 4 to 6: peak speed and divider numerators
	logic [PK_W-1:0] pk_max;
	logic [V_W-1:0]  vp_s4, vp_s5;
	sqs_t            sq_s4, sq_s5;
	logic [SQ_W-1:0] vpsq_s5;
	logic [NA_W-1:0] tan_s5, tdn_s5;
	logic [NA_W-1:0] num_s6 [4];
	dv1_t            d1_s6;
	logic [AC2_W-1:0] den1 [4];

	always_comb begin
		pk_max = pk;
		if (PK_W'(sq_o.b.v0) > pk_max) pk_max = PK_W'(sq_o.b.v0);
		if (PK_W'(sq_o.b.v1) > pk_max) pk_max = PK_W'(sq_o.b.v1);
		if (pk_max > PK_W'(sq_o.b.vmax)) pk_max = PK_W'(sq_o.b.vmax);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vp_s4 <= V_W'(pk_max);
			sq_s4 <= sq_o;

			vp_s5   <= vp_s4;
			sq_s5   <= sq_s4;
			vpsq_s5 <= SQ_W'(vp_s4) * SQ_W'(vp_s4);
			tan_s5  <= NA_W'(vp_s4 - sq_s4.b.v0) << F;
			tdn_s5  <= NA_W'(vp_s4 - sq_s4.b.v1) << F;

			num_s6[0] <= tan_s5;
			num_s6[1] <= tdn_s5;
			num_s6[2] <= NA_W'(vpsq_s5 - sq_s5.v0sq);
			num_s6[3] <= NA_W'(vpsq_s5 - sq_s5.v1sq);
			d1_s6.b   <= sq_s5.b;
			d1_s6.vp  <= vp_s5;
		end
	end

	assign den1[0] = AC2_W'(d1_s6.b.acc);
	assign den1[1] = AC2_W'(d1_s6.b.acc);
	assign den1[2] = {d1_s6.b.acc, 1'b0};
	assign den1[3] = {d1_s6.b.acc, 1'b0};

	// accel time, decel time, accel distance, decel distance
	logic [NA_W-1:0] q1 [4];
	dv1_t            d1_o;

	tps_div_pipe #(
		.NW    (NA_W),
		.DW    (AC2_W),
		.LANES (4),
		.SW    ($bits(dv1_t))
	) u_div_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (num_s6),
		.den       (den1),
		.side_in   (d1_s6),
		.out_valid (v_d1),
		.quo       (q1),
		.side_out  (d1_o)
	);

	// stages 7 and 8: cruise distance
	dv1_t            d1_s7;
	logic [NA_W-1:0] ta_s7, td_s7, da_s7;
	logic [NA_W:0]   sdd_s7;
	dv2_t            d2_s8;
	logic [TC_W-1:0] num2 [1];
	logic [V_W-1:0]  den2 [1];

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s7  <= d1_o;
			ta_s7  <= q1[0];
			td_s7  <= q1[1];
			da_s7  <= q1[2];
			sdd_s7 <= (NA_W+1)'(q1[2]) + (NA_W+1)'(q1[3]);

			d2_s8.b  <= d1_s7.b;
			d2_s8.vp <= d1_s7.vp;
			d2_s8.ta <= ta_s7;
			d2_s8.td <= td_s7;
			d2_s8.da <= da_s7;
			d2_s8.dc <= (sdd_s7 >= (NA_W+1)'(d1_s7.b.d)) ? '0
				: d1_s7.b.d - D_W'(sdd_s7);
		end
	end

	assign num2[0] = TC_W'(d2_s8.dc) << F;
	assign den2[0] = d2_s8.vp;

	// cruise time
	logic [TC_W-1:0] q2 [1];
	dv2_t            d2_o;

	tps_div_pipe #(
		.NW    (TC_W),
		.DW    (V_W),
		.LANES (1),
		.SW    ($bits(dv2_t))
	) u_div_cruise (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s8),
		.num       (num2),
		.den       (den2),
		.side_in   (d2_s8),
		.out_valid (v_d2),
		.quo       (q2),
		.side_out  (d2_o)
	);

	// stages 9 to 18: duration, phase and sample
	lt_t l_s9, l_s10, l_s11, l_s12, l_s13, l_s14, l_s15, l_s16, l_s17, l_s18;
	lt_t n9, n10, n11, n12, n13, n14, n15, n16, n17, n18;
	logic [TC_W-1:0]  tc_eff;
	logic [DUR_W-1:0] dsum;
	logic [M_W-1:0]   half;
	logic [M_W:0]     asum;
	logic [PW-1:0]    magx;

	always_comb begin
		tc_eff  = (d2_o.vp > THR) ? q2[0] : '0;
		n9      = '0;
		n9.b    = d2_o.b;
		n9.vp   = d2_o.vp;
		n9.ta   = d2_o.ta;
		n9.td   = d2_o.td;
		n9.da   = d2_o.da;
		n9.dc   = d2_o.dc;
		n9.tatc = DUR_W'(d2_o.ta) + DUR_W'(tc_eff);
	end

	always_comb begin
		n10    = l_s9;
		dsum   = l_s9.tatc + DUR_W'(l_s9.td);
		n10.dur = (dsum < DUR_W'(K05)) ? DUR_W'(K05) : dsum;
	end

	always_comb begin
		n11     = l_s10;
		n11.fin = DUR_W'(l_s10.b.el) >= l_s10.dur;
		n11.t   = n11.fin ? T_W'(l_s10.dur) : l_s10.b.el;
	end

	always_comb begin
		n12 = l_s11;
		priority if (DUR_W'(l_s11.t) < DUR_W'(l_s11.ta)) begin
			n12.ph = PH_ACCEL;
			n12.x  = l_s11.t;
		end else if (DUR_W'(l_s11.t) < l_s11.tatc) begin
			n12.ph = PH_CRUISE;
			n12.x  = l_s11.t - T_W'(l_s11.ta);
		end else begin
			n12.ph = PH_DECEL;
			n12.x  = l_s11.t - T_W'(l_s11.tatc);
		end
	end

	always_comb begin
		n13    = l_s12;
		n13.m1 = M_W'(l_s12.b.acc) * M_W'(l_s12.x);
		n13.m2 = M_W'((l_s12.ph == PH_ACCEL) ? l_s12.b.v0 : l_s12.vp) * M_W'(l_s12.x);
	end

	// speed change stays below the 20-bit speed range within the accel and decel phases
	always_comb begin
		n14    = l_s13;
		n14.dv = l_s13.m1[F +: V_W];
	end

	always_comb begin
		n15    = l_s14;
		n15.m3 = M_W'(l_s14.dv) * M_W'(l_s14.x);
		unique case (l_s14.ph)
			PH_ACCEL:  n15.vel = (V_W+1)'(l_s14.b.v0) + (V_W+1)'(l_s14.dv);
			PH_CRUISE: n15.vel = (V_W+1)'(l_s14.vp);
			PH_DECEL: begin
				if (l_s14.dv >= l_s14.vp || l_s14.vp - l_s14.dv < l_s14.b.v1) begin
					n15.vel = (V_W+1)'(l_s14.b.v1);
				end else begin
					n15.vel = (V_W+1)'(l_s14.vp - l_s14.dv);
				end
			end
			default:   n15.vel = '0;
		endcase
	end

	always_comb begin
		n16  = l_s15;
		half = l_s15.m3 >> 1;
		asum = (M_W+1)'(l_s15.m2) + (M_W+1)'(half);
		unique case (l_s15.ph)
			PH_ACCEL: begin
				n16.mag  = MAG_W'(asum >> F);
				n16.neg  = 1'b0;
				n16.base = '0;
			end
			PH_CRUISE: begin
				n16.mag  = MAG_W'(l_s15.m2 >> F);
				n16.neg  = 1'b0;
				n16.base = PW'(l_s15.da);
			end
			PH_DECEL: begin
				// distance gained at peak speed minus the braking loss
				if (l_s15.m2 >= half) begin
					n16.mag = MAG_W'((l_s15.m2 - half) >> F);
					n16.neg = 1'b0;
				end else begin
					n16.mag = MAG_W'((half - l_s15.m2) >> F);
					n16.neg = 1'b1;
				end
				n16.base = PW'(l_s15.da) + PW'(l_s15.dc);
			end
			default: begin
				n16.mag  = '0;
				n16.neg  = 1'b0;
				n16.base = '0;
			end
		endcase
	end

	always_comb begin
		n17  = l_s16;
		magx = PW'(l_s16.mag);
		if (l_s16.neg) begin
			n17.pos = (magx >= l_s16.base) ? '0 : l_s16.base - magx;
		end else begin
			n17.pos = l_s16.base + magx;
		end
	end

	always_comb begin
		n18 = l_s17;
		if (l_s17.ph == PH_DECEL) begin
			if (l_s17.fin) begin
				n18.pos = PW'(l_s17.b.d);
				n18.vel = (V_W+1)'(l_s17.b.v1);
			end else if (l_s17.pos > PW'(l_s17.b.d)) begin
				n18.pos = PW'(l_s17.b.d);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s9  <= n9;
			l_s10 <= n10;
			l_s11 <= n11;
			l_s12 <= n12;
			l_s13 <= n13;
			l_s14 <= n14;
			l_s15 <= n15;
			l_s16 <= n16;
			l_s17 <= n17;
			l_s18 <= n18;
		end
	end

	// result register
	logic [D_W-1:0] pos_q;
	logic [V_W-1:0] spd_q;
	logic [T_W-1:0] dur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (out_ld) begin
			res_vld_q <= v_s18;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (l_s18.b.tiny) begin
				pos_q <= '0;
				spd_q <= '0;
				dur_q <= '0;
			end else begin
				pos_q <= (l_s18.pos > PW'({D_W{1'b1}})) ? '1 : D_W'(l_s18.pos);
				spd_q <= (l_s18.vel > (V_W+1)'({V_W{1'b1}})) ? '1 : V_W'(l_s18.vel);
				dur_q <= (l_s18.dur > DUR_W'({T_W{1'b1}})) ? '1 : T_W'(l_s18.dur);
			end
		end
	end

	assign results.valid         = res_vld_q;
	assign results.ref_position  = pos_q;
	assign results.ref_speed     = spd_q;
	assign results.move_duration = dur_q;

endmodule
